// ===== sv/lcci_pkg.sv =====
package lcci_pkg;

    // Field widths
    localparam int CW  = 24;   // coordinate / packed color width
    localparam int DW  = 25;   // per-axis delta width
    localparam int QW  = 26;   // plane numerator / denominator width
    localparam int MW  = 25;   // divider operand magnitude width
    localparam int TW  = 33;   // line parameter bits, 1.0 = 2^32
    localparam int TB  = 32;   // fraction bits of the line parameter
    localparam int LW  = 23;   // clip limit width
    localparam int NAX = 3;
    localparam int NPL = 6;
    localparam int SPL = 17;   // split point of the coordinate multiply

    localparam logic [TW:0] TONE = (TW+1)'(1) << TB;
    localparam logic [TW:0] TBIG = TONE + (TW+1)'(1);

    localparam int LIM_MAX = 32'h7F_FFFF;

    typedef struct packed {
        logic [NAX-1:0][CW-1:0] s;
        logic [NAX-1:0][DW-1:0] d;
        logic [CW-1:0]          c0;
        logic [CW-1:0]          c1;
    } t_side;

    typedef struct packed {
        logic den_pos;
        logic den_zero;
        logic num_pos;
        logic num_zero;
        logic big;
    } t_pflag;

endpackage

// ===== sv/line_clip_color_interp.sv =====
// Channel   Handshake               Payload
// --------  ----------------------  ------------------------------------------
// segment   start / busy            i_start_*, i_end_*, i_start_color, i_end_color
// result    o_valid (one cycle)     o_is_visible, o_clip_*, o_clip_*_color
// config    i_cfg_we                i_cfg_wdata (clip limit)
//
// One segment is taken every cycle; busy stays low.
// The pipeline holds a 33-step restoring divider per plane
// (one quotient bit per stage) plus input, compare and multiply stages.
// Reset is synchronous: it clears the valid bits and loads the clip limit.
// The receiver cannot stall, so the pipeline never holds.
module line_clip_color_interp
    import lcci_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CW-1:0]        i_start_x,
    input  logic [CW-1:0]        i_start_y,
    input  logic [CW-1:0]        i_start_z,
    input  logic [CW-1:0]        i_end_x,
    input  logic [CW-1:0]        i_end_y,
    input  logic [CW-1:0]        i_end_z,
    input  logic [CW-1:0]        i_start_color,
    input  logic [CW-1:0]        i_end_color,
    input  logic                 i_cfg_we,
    input  logic [LW-1:0]        i_cfg_wdata,
    output logic                 o_valid,
    output logic                 o_is_visible,
    output logic [CW-1:0]        o_clip_start_x,
    output logic [CW-1:0]        o_clip_start_y,
    output logic [CW-1:0]        o_clip_start_z,
    output logic [CW-1:0]        o_clip_end_x,
    output logic [CW-1:0]        o_clip_end_y,
    output logic [CW-1:0]        o_clip_end_z,
    output logic [CW-1:0]        o_clip_start_color,
    output logic [CW-1:0]        o_clip_end_color
);

    localparam int LIM_ONE = 1 << FRAC_BITS;
    localparam int LIM_SAT = (LIM_ONE > LIM_MAX) ? LIM_MAX : LIM_ONE;
    localparam logic [LW-1:0] LIM_RST = LW'(LIM_SAT);
    localparam int LAT = TW + 8;
    localparam logic [59:0] RND60 = 60'(1) << (TB - 1);
    localparam logic [42:0] RND43 = 43'(1) << (TB - 1);

    logic [LW-1:0] r_limit;

    assign busy = 1'b0;

    // Clip limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_RST;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Stage 1: deltas and plane numerators / denominators
    logic                  r_s1_v;
    t_side                 r_s1_side;
    logic signed [QW-1:0]  r_s1_den [NPL];
    logic signed [QW-1:0]  r_s1_num [NPL];
    t_side                 n_s1_side;
    logic signed [QW-1:0]  n_s1_den [NPL];
    logic signed [QW-1:0]  n_s1_num [NPL];
    logic [NAX-1:0][CW-1:0] w_st;
    logic [NAX-1:0][CW-1:0] w_en;

    assign w_st = {i_start_z, i_start_y, i_start_x};
    assign w_en = {i_end_z, i_end_y, i_end_x};

    always_comb begin
        logic signed [QW-1:0] lim;
        logic signed [QW-1:0] sv;
        logic signed [QW-1:0] dv;
        lim = $signed({{(QW-LW){1'b0}}, r_limit});
        n_s1_side.c0 = i_start_color;
        n_s1_side.c1 = i_end_color;
        for (int i = 0; i < NAX; i++) begin
            sv = QW'($signed(w_st[i]));
            dv = QW'($signed(w_en[i])) - sv;
            n_s1_side.s[i] = w_st[i];
            n_s1_side.d[i] = dv[DW-1:0];
            n_s1_den[2*i]   = dv;
            n_s1_num[2*i]   = -lim - sv;
            n_s1_den[2*i+1] = -dv;
            n_s1_num[2*i+1] = sv - lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= start && !busy;
        end
        r_s1_side <= n_s1_side;
        r_s1_den  <= n_s1_den;
        r_s1_num  <= n_s1_num;
    end

    // Divider pipeline storage; entry 0 holds the magnitudes and sign flags
    logic             r_dv   [TW+1];
    t_side            r_dside[TW+1];
    logic [MW-1:0]    r_rem  [TW+1][NPL];
    logic [MW-1:0]    r_b    [TW+1][NPL];
    logic [TW-1:0]    r_quo  [TW+1][NPL];
    t_pflag           r_flg  [TW+1][NPL];

    // Stage 2: magnitudes and signs of each plane test
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_s1_v;
        end
        r_dside[0] <= r_s1_side;
        for (int k = 0; k < NPL; k++) begin
            r_rem[0][k] <= r_s1_num[k][QW-1] ? MW'(-r_s1_num[k]) : MW'(r_s1_num[k]);
            r_b[0][k]   <= r_s1_den[k][QW-1] ? MW'(-r_s1_den[k]) : MW'(r_s1_den[k]);
            r_quo[0][k] <= '0;
            r_flg[0][k].den_zero <= (r_s1_den[k] == '0);
            r_flg[0][k].den_pos  <= !r_s1_den[k][QW-1] && (r_s1_den[k] != '0);
            r_flg[0][k].num_zero <= (r_s1_num[k] == '0);
            r_flg[0][k].num_pos  <= !r_s1_num[k][QW-1] && (r_s1_num[k] != '0);
            r_flg[0][k].big      <= 1'b0;
        end
    end

    // Restoring division, one quotient bit per stage, MSB (weight 1.0) first
    for (genvar gk = 0; gk < TW; gk++) begin : g_div
        logic [MW:0]   n_sh [NPL];
        logic          n_bit[NPL];
        logic [MW-1:0] n_rem[NPL];
        t_pflag        n_flg[NPL];

        always_comb begin
            for (int k = 0; k < NPL; k++) begin
                n_sh[k]  = (gk == 0) ? {1'b0, r_rem[gk][k]} : {r_rem[gk][k], 1'b0};
                n_bit[k] = (n_sh[k] >= {1'b0, r_b[gk][k]});
                n_rem[k] = n_bit[k] ? MW'(n_sh[k] - {1'b0, r_b[gk][k]}) : MW'(n_sh[k]);
                n_flg[k] = r_flg[gk][k];
                if (gk == 0) begin
                    n_flg[k].big = (r_rem[gk][k] > r_b[gk][k]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gk+1] <= 1'b0;
            end else begin
                r_dv[gk+1] <= r_dv[gk];
            end
            r_dside[gk+1] <= r_dside[gk];
            for (int k = 0; k < NPL; k++) begin
                r_rem[gk+1][k] <= n_rem[k];
                r_b[gk+1][k]   <= r_b[gk][k];
                r_quo[gk+1][k] <= {r_quo[gk][k][TW-2:0], n_bit[k]};
                r_flg[gk+1][k] <= n_flg[k];
            end
        end
    end

    // C1: per-plane entry / exit parameters and rejects
    logic            r_c1_v;
    t_side           r_c1_side;
    logic [TW:0]     r_c1_te [NPL];
    logic [TW:0]     r_c1_tl [NPL];
    logic [NPL-1:0]  r_c1_rej;
    logic [TW:0]     n_c1_te [NPL];
    logic [TW:0]     n_c1_tl [NPL];
    logic [NPL-1:0]  n_c1_rej;

    always_comb begin
        t_pflag f;
        logic [TW:0] tv;
        for (int k = 0; k < NPL; k++) begin
            f  = r_flg[TW][k];
            tv = {1'b0, r_quo[TW][k]};
            n_c1_te[k]  = '0;
            n_c1_tl[k]  = TONE;
            n_c1_rej[k] = 1'b0;
            if (f.den_zero) begin
                n_c1_rej[k] = f.num_pos;
            end else if (f.den_pos) begin
                if (f.num_pos) begin
                    n_c1_te[k] = f.big ? TBIG : tv;
                end
            end else begin
                if (f.num_pos) begin
                    n_c1_rej[k] = 1'b1;
                end else if (f.num_zero) begin
                    n_c1_tl[k] = '0;
                end else begin
                    n_c1_tl[k] = f.big ? TONE : tv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
        end else begin
            r_c1_v <= r_dv[TW];
        end
        r_c1_side <= r_dside[TW];
        r_c1_te   <= n_c1_te;
        r_c1_tl   <= n_c1_tl;
        r_c1_rej  <= n_c1_rej;
    end

    // C2: latest entry, earliest exit
    logic        r_c2_v;
    t_side       r_c2_side;
    logic [TW:0] r_c2_te;
    logic [TW:0] r_c2_tl;
    logic        r_c2_rej;
    logic [TW:0] n_c2_te;
    logic [TW:0] n_c2_tl;

    always_comb begin
        n_c2_te = '0;
        n_c2_tl = TONE;
        for (int k = 0; k < NPL; k++) begin
            if (r_c1_te[k] > n_c2_te) begin
                n_c2_te = r_c1_te[k];
            end
            if (r_c1_tl[k] < n_c2_tl) begin
                n_c2_tl = r_c1_tl[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_v <= 1'b0;
        end else begin
            r_c2_v <= r_c1_v;
        end
        r_c2_side <= r_c1_side;
        r_c2_te   <= n_c2_te;
        r_c2_tl   <= n_c2_tl;
        r_c2_rej  <= |r_c1_rej;
    end

    // C3: visibility and which endpoints move
    logic        r_c3_v;
    t_side       r_c3_side;
    logic [TW:0] r_c3_te;
    logic [TW:0] r_c3_tl;
    logic        r_c3_vis;
    logic        r_c3_mvs;
    logic        r_c3_mve;
    logic        n_c3_vis;

    assign n_c3_vis = !r_c2_rej && (r_c2_te <= r_c2_tl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3_v <= 1'b0;
        end else begin
            r_c3_v <= r_c2_v;
        end
        r_c3_side <= r_c2_side;
        r_c3_te   <= r_c2_te;
        r_c3_tl   <= r_c2_tl;
        r_c3_vis  <= n_c3_vis;
        r_c3_mvs  <= n_c3_vis && (r_c2_te != '0);
        r_c3_mve  <= n_c3_vis && (r_c2_tl != TONE);
    end

    // M1: partial products of delta * t and color differences * t
    logic               r_m1_v;
    t_side              r_m1_side;
    logic               r_m1_vis;
    logic               r_m1_mvs;
    logic               r_m1_mve;
    logic signed [42:0] r_m1_lo [2][NAX];
    logic signed [41:0] r_m1_hi [2][NAX];
    logic signed [42:0] r_m1_cp [2][NAX];
    logic signed [42:0] n_m1_lo [2][NAX];
    logic signed [41:0] n_m1_hi [2][NAX];
    logic signed [42:0] n_m1_cp [2][NAX];

    always_comb begin
        logic [TW-1:0]     tt;
        logic signed [8:0] cd;
        for (int e = 0; e < 2; e++) begin
            tt = (e == 0) ? r_c3_te[TW-1:0] : r_c3_tl[TW-1:0];
            for (int i = 0; i < NAX; i++) begin
                n_m1_lo[e][i] = 43'($signed(r_c3_side.d[i]) * $signed({1'b0, tt[SPL-1:0]}));
                n_m1_hi[e][i] = 42'($signed(r_c3_side.d[i]) * $signed({1'b0, tt[TW-1:SPL]}));
                cd = $signed({1'b0, r_c3_side.c1[8*i +: 8]})
                   - $signed({1'b0, r_c3_side.c0[8*i +: 8]});
                n_m1_cp[e][i] = 43'(cd * $signed({1'b0, tt}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else begin
            r_m1_v <= r_c3_v;
        end
        r_m1_side <= r_c3_side;
        r_m1_vis  <= r_c3_vis;
        r_m1_mvs  <= r_c3_mvs;
        r_m1_mve  <= r_c3_mve;
        r_m1_lo   <= n_m1_lo;
        r_m1_hi   <= n_m1_hi;
        r_m1_cp   <= n_m1_cp;
    end

    // M2: combine coordinate partial products
    logic               r_m2_v;
    t_side              r_m2_side;
    logic               r_m2_vis;
    logic               r_m2_mvs;
    logic               r_m2_mve;
    logic signed [59:0] r_m2_sum [2][NAX];
    logic signed [42:0] r_m2_cp  [2][NAX];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else begin
            r_m2_v <= r_m1_v;
        end
        r_m2_side <= r_m1_side;
        r_m2_vis  <= r_m1_vis;
        r_m2_mvs  <= r_m1_mvs;
        r_m2_mve  <= r_m1_mve;
        r_m2_cp   <= r_m1_cp;
        for (int e = 0; e < 2; e++) begin
            for (int i = 0; i < NAX; i++) begin
                r_m2_sum[e][i] <= (60'(r_m1_hi[e][i]) <<< SPL) + 60'(r_m1_lo[e][i]);
            end
        end
    end

    // M3: round, offset from the start point and select pass-through
    logic [NAX-1:0][CW-1:0] n_ps;
    logic [NAX-1:0][CW-1:0] n_pe;
    logic [CW-1:0]          n_cs;
    logic [CW-1:0]          n_ce;

    always_comb begin
        logic [59:0] rs;
        logic [42:0] rc;
        for (int i = 0; i < NAX; i++) begin
            rs = r_m2_sum[0][i] + RND60;
            n_ps[i] = r_m2_mvs ? r_m2_side.s[i] + rs[TB +: CW] : r_m2_side.s[i];
            rs = r_m2_sum[1][i] + RND60;
            n_pe[i] = r_m2_mve ? r_m2_side.s[i] + rs[TB +: CW]
                               : r_m2_side.s[i] + CW'(r_m2_side.d[i]);
            rc = r_m2_cp[0][i] + RND43;
            n_cs[8*i +: 8] = r_m2_mvs ? r_m2_side.c0[8*i +: 8] + rc[TB +: 8]
                                      : r_m2_side.c0[8*i +: 8];
            rc = r_m2_cp[1][i] + RND43;
            n_ce[8*i +: 8] = r_m2_mve ? r_m2_side.c0[8*i +: 8] + rc[TB +: 8]
                                      : r_m2_side.c1[8*i +: 8];
        end
    end

    logic                   r_out_v;
    logic                   r_out_vis;
    logic [NAX-1:0][CW-1:0] r_out_ps;
    logic [NAX-1:0][CW-1:0] r_out_pe;
    logic [CW-1:0]          r_out_cs;
    logic [CW-1:0]          r_out_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_m2_v;
        end
        r_out_vis <= r_m2_vis;
        r_out_ps  <= n_ps;
        r_out_pe  <= n_pe;
        r_out_cs  <= n_cs;
        r_out_ce  <= n_ce;
    end

    assign o_valid            = r_out_v;
    assign o_is_visible       = r_out_vis;
    assign o_clip_start_x     = r_out_ps[0];
    assign o_clip_start_y     = r_out_ps[1];
    assign o_clip_start_z     = r_out_ps[2];
    assign o_clip_end_x       = r_out_pe[0];
    assign o_clip_end_y       = r_out_pe[1];
    assign o_clip_end_z       = r_out_pe[2];
    assign o_clip_start_color = r_out_cs;
    assign o_clip_end_color   = r_out_ce;

`ifndef SYNTHESIS
    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a transfer LAT cycles earlier");

    a_hidden_color : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_visible |-> o_clip_start_color == $past(i_start_color, LAT))
        else $error("invisible segment changed its start color");

    a_t_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c3_v && r_c3_vis |=> r_m1_vis && ($past(r_c3_tl) <= TONE))
        else $error("visible segment with exit parameter above one");
`endif

endmodule

// ===== tb/line_clip_color_interp_tb.sv =====
module line_clip_color_interp_tb;
    import lcci_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint T_ONE     = longint'(1) << 32;
    localparam longint T_HALF    = longint'(1) << 31;
    localparam int     STALL_MAX = 5000;
    localparam int     DRAIN_CYC = 60;
    localparam int     N_PHASE   = 6;
    localparam int     PER_PHASE = 225;

    // One segment and one clip result
    typedef struct {
        logic [CW-1:0] sx, sy, sz, ex, ey, ez, c0, c1;
    } t_seg;

    typedef struct {
        logic          vis;
        logic [CW-1:0] sx, sy, sz, ex, ey, ez, c0, c1;
    } t_clip;

    // Directed row: kind tells how the expected result is obtained
    typedef enum int {BY_MODEL, PASS_HIDDEN, PASS_INSIDE} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_seg      seg;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [CW-1:0] i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic [CW-1:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic [CW-1:0] i_start_color = '0, i_end_color = '0;
    logic          i_cfg_we = 1'b0;
    logic [LW-1:0] i_cfg_wdata = '0;
    logic          o_valid, o_is_visible;
    logic [CW-1:0] o_clip_start_x, o_clip_start_y, o_clip_start_z;
    logic [CW-1:0] o_clip_end_x, o_clip_end_y, o_clip_end_z;
    logic [CW-1:0] o_clip_start_color, o_clip_end_color;

    logic [LW-1:0] cube_half = LW'(1 << 16);
    t_clip         clip_q[$];
    bit            use_typed = 1'b0;
    t_clip         typed_clip;
    int            mismatches = 0;
    int            fails = 0;
    int            segs_sent = 0;
    int            segs_seen = 0;
    int            shown_visible = 0;
    int            stall_cycles = 0;

    line_clip_color_interp u_dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_start_x, .i_start_y, .i_start_z, .i_end_x, .i_end_y, .i_end_z,
        .i_start_color, .i_end_color, .i_cfg_we, .i_cfg_wdata,
        .o_valid, .o_is_visible,
        .o_clip_start_x, .o_clip_start_y, .o_clip_start_z,
        .o_clip_end_x, .o_clip_end_y, .o_clip_end_z,
        .o_clip_start_color, .o_clip_end_color
    );

    always #5 i_clk = ~i_clk;

    // Floor of (p / 2^32 + 1/2)
    function automatic longint round_t32(longint p);
        return (p + T_HALF) >>> 32;
    endfunction

    // Update entry/exit for one plane; return 0 when the plane rejects
    function automatic bit plane_keeps(longint den, longint num,
                                       inout longint te, inout longint tl);
        longint a, b, t;
        if (den == 0) return num <= 0;
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        t = (a << 32) / b;
        if ((num < 0) != (den < 0)) t = -t;
        if (den > 0) begin
            if (t > tl) return 1'b0;
            if (t > te) te = t;
        end else begin
            if (t < te) return 1'b0;
            if (t < tl) tl = t;
        end
        return 1'b1;
    endfunction

    function automatic logic [CW-1:0] blend_color(logic [CW-1:0] c0, logic [CW-1:0] c1,
                                                  longint t);
        logic [CW-1:0] res;
        longint a, b;
        res = '0;
        for (int sh = 0; sh < 24; sh += 8) begin
            a = longint'(c0[sh +: 8]);
            b = longint'(c1[sh +: 8]);
            res[sh +: 8] = 8'(a + round_t32((b - a) * t));
        end
        return res;
    endfunction

    // Liang-Barsky clip of one segment against the cube of half size lim
    function automatic t_clip clip_segment(t_seg g, logic [LW-1:0] lim);
        longint s[3], d[3], a[3], b[3];
        longint te, tl, l;
        bit vis;
        t_clip r;
        s[0] = longint'($signed(g.sx));
        s[1] = longint'($signed(g.sy));
        s[2] = longint'($signed(g.sz));
        d[0] = longint'($signed(g.ex)) - s[0];
        d[1] = longint'($signed(g.ey)) - s[1];
        d[2] = longint'($signed(g.ez)) - s[2];
        l = longint'(lim);
        te = 0;
        tl = T_ONE;
        vis = 1'b1;
        for (int i = 0; i < 3 && vis; i++)
            vis = plane_keeps(d[i], -l - s[i], te, tl)
               && plane_keeps(-d[i], s[i] - l, te, tl);
        for (int i = 0; i < 3; i++) begin
            a[i] = (vis && te > 0) ? s[i] + round_t32(d[i] * te) : s[i];
            b[i] = (vis && tl < T_ONE) ? s[i] + round_t32(d[i] * tl) : s[i] + d[i];
        end
        r.vis = vis;
        r.sx = CW'(a[0]); r.sy = CW'(a[1]); r.sz = CW'(a[2]);
        r.ex = CW'(b[0]); r.ey = CW'(b[1]); r.ez = CW'(b[2]);
        r.c0 = (vis && te > 0) ? blend_color(g.c0, g.c1, te) : g.c0;
        r.c1 = (vis && tl < T_ONE) ? blend_color(g.c0, g.c1, tl) : g.c1;
        return r;
    endfunction

    function automatic t_clip pass_through(t_seg g, logic vis);
        t_clip r;
        r.vis = vis;
        r.sx = g.sx; r.sy = g.sy; r.sz = g.sz;
        r.ex = g.ex; r.ey = g.ey; r.ez = g.ez;
        r.c0 = g.c0; r.c1 = g.c1;
        return r;
    endfunction

    // Coordinate biased toward the cube faces, with some full-range values
    function automatic logic [CW-1:0] pick_coord(logic [LW-1:0] lim);
        int span, v;
        span = 2 * int'(lim) + 1;
        case ($urandom_range(9))
            0, 1:    v = int'($signed(CW'($urandom)));
            2:       v = $urandom_range(1) ? int'(lim) : -int'(lim);
            3:       v = 0;
            default: v = int'($urandom_range(2 * span)) - span;
        endcase
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return CW'(v);
    endfunction

    // Send one segment, with random idle cycles ahead of it
    task automatic send_segment(t_seg g, int idle_pct, t_row_kind kind);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        use_typed     = (kind != BY_MODEL);
        typed_clip    = pass_through(g, kind == PASS_INSIDE);
        start         <= 1'b1;
        i_start_x     <= g.sx;
        i_start_y     <= g.sy;
        i_start_z     <= g.sz;
        i_end_x       <= g.ex;
        i_end_y       <= g.ey;
        i_end_z       <= g.ez;
        i_start_color <= g.c0;
        i_end_color   <= g.c1;
        do @(posedge i_clk); while (busy);
        segs_sent++;
    endtask

    // Wait for all results, then let the pipeline empty
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        wait (clip_q.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LW-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        cube_half = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Predict on each transfer in, check each result out
    always @(posedge i_clk) begin
        t_clip e;
        t_clip want;
        t_seg  g_in;
        if (i_rst_n && start && !busy) begin
            g_in.sx = i_start_x; g_in.sy = i_start_y; g_in.sz = i_start_z;
            g_in.ex = i_end_x;   g_in.ey = i_end_y;   g_in.ez = i_end_z;
            g_in.c0 = i_start_color;
            g_in.c1 = i_end_color;
            want = use_typed ? typed_clip : clip_segment(g_in, cube_half);
            clip_q.insert(clip_q.size(), want);
        end
        if (o_valid) begin
            segs_seen++;
            if (o_is_visible) shown_visible++;
            if (clip_q.size() == 0) begin
                fails++;
                $display("unexpected result at %0t", $time);
            end else begin
                e = clip_q.pop_front();
                if (o_is_visible !== e.vis || o_clip_start_x !== e.sx
                    || o_clip_start_y !== e.sy || o_clip_start_z !== e.sz
                    || o_clip_end_x !== e.ex || o_clip_end_y !== e.ey
                    || o_clip_end_z !== e.ez || o_clip_start_color !== e.c0
                    || o_clip_end_color !== e.c1) begin
                    fails++;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: exp vis=%0b s=%h,%h,%h e=%h,%h,%h c=%h,%h",
                            $time, e.vis, e.sx, e.sy, e.sz, e.ex, e.ey, e.ez, e.c0, e.c1);
                        $display("                got vis=%0b s=%h,%h,%h e=%h,%h,%h c=%h,%h",
                            o_is_visible, o_clip_start_x, o_clip_start_y, o_clip_start_z,
                            o_clip_end_x, o_clip_end_y, o_clip_end_z,
                            o_clip_start_color, o_clip_end_color);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_seg g;
        logic [LW-1:0] limits[N_PHASE];
        int idle_pct;

        // Directed segments at the reset limit of 1.0 (0x010000)
        rows = '{
            '{PASS_INSIDE, '{24'h008000, 24'h000000, 24'h000000,
                             24'hFF8000, 24'h004000, 24'h000000, 24'h123456, 24'hABCDEF}},
            '{PASS_HIDDEN, '{24'h020000, 24'h000000, 24'h000000,
                             24'h020000, 24'h008000, 24'h004000, 24'h00FF00, 24'hFF0000}},
            '{BY_MODEL,    '{24'h800000, 24'h800000, 24'h800000,
                             24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h000000, 24'hFFFFFF}},
            '{BY_MODEL,    '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                             24'h800000, 24'h800000, 24'h800000, 24'hFFFFFF, 24'h000000}},
            '{BY_MODEL,    '{24'hFE0000, 24'h000000, 24'h000000,
                             24'h020000, 24'h000000, 24'h000000, 24'h000000, 24'hFF00FF}},
            '{PASS_INSIDE, '{24'h010000, 24'h010000, 24'h010000,
                             24'h010000, 24'h010000, 24'h010000, 24'h0F0F0F, 24'hF0F0F0}},
            '{PASS_HIDDEN, '{24'h020000, 24'h000000, 24'h000000,
                             24'h020000, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000}},
            '{PASS_HIDDEN, '{24'h000000, 24'h028000, 24'h000000,
                             24'h028000, 24'h000000, 24'h000000, 24'h010203, 24'h040506}},
            '{BY_MODEL,    '{24'h000000, 24'hFD0000, 24'h000000,
                             24'h000000, 24'h010000, 24'h000000, 24'h000001, 24'h000000}},
            '{BY_MODEL,    '{24'h000000, 24'h000000, 24'h000000,
                             24'h000000, 24'h000000, 24'h040000, 24'h00FF80, 24'hFF0001}},
            '{PASS_INSIDE, '{24'h000000, 24'h000000, 24'h000000,
                             24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000}},
            '{PASS_HIDDEN, '{24'h000000, 24'hFE0000, 24'h000000,
                             24'h008000, 24'hFE0000, 24'h000000, 24'hAAAAAA, 24'h555555}},
            '{BY_MODEL,    '{24'h018000, 24'hFE8000, 24'h00C000,
                             24'hFE8000, 24'h018000, 24'hFF4000, 24'hFFFFFF, 24'hFFFFFF}},
            '{BY_MODEL,    '{24'h000000, 24'h000000, 24'hFF0000,
                             24'h000000, 24'h000000, 24'h7FFFFF, 24'h800080, 24'h7F7F7F}}
        };
        limits = '{LW'(0), LW'(LIM_MAX), LW'(1 << 16),
                   LW'($urandom_range(32'h40000, 1)), LW'($urandom), LW'(1)};

        // Hold reset, then release it on a falling clock edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_segment(rows[i].seg, 0, rows[i].kind);
        end

        // Random segments over several cube sizes and idle patterns
        for (int p = 0; p < N_PHASE; p++) begin
            drain();
            write_limit(limits[p]);
            idle_pct = (p % 3 == 0) ? 23 : (p % 3 == 1) ? 74 : 0;
            for (int n = 0; n < PER_PHASE; n++) begin
                g.sx = pick_coord(cube_half);
                g.sy = pick_coord(cube_half);
                g.sz = pick_coord(cube_half);
                g.ex = pick_coord(cube_half);
                g.ey = pick_coord(cube_half);
                g.ez = pick_coord(cube_half);
                g.c0 = CW'($urandom);
                g.c1 = CW'($urandom);
                send_segment(g, ($urandom_range(7) == 0) ? 0 : idle_pct, BY_MODEL);
            end
        end
        drain();

        if (clip_q.size() != 0) fails++;
        $display("Sent %0d segments over %0d cube sizes; %0d results, %0d visible.",
                 segs_sent, N_PHASE + 1, segs_seen, shown_visible);
        $display("Mismatches: %0d", mismatches);
        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
